[sv/alg_pkg.sv]
package alg_pkg;
    localparam int SampleBitsDef = 24;
    localparam int GainW = 24;
    localparam int PowW = 32;
    localparam int CoefW = 24;
    localparam int CfgDataW = 32;
    localparam int CfgIdxW = 3;
    localparam logic [GainW-1:0] UnityGain = 24'd1048576;

    localparam logic [CfgIdxW-1:0] REG_MEASURE = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_GLIDE   = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_GATE    = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_MINC    = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_MAXC    = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_ENABLE  = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_STEREO  = 3'd6;

    // one-pole step: x moves toward y by round(c*|y-x|/2^24)
    function automatic logic [PowW-1:0] approach(input logic [PowW-1:0] x,
                                                 input logic [PowW-1:0] y,
                                                 input logic [CoefW-1:0] c);
        logic [PowW-1:0] d;
        logic [PowW+CoefW:0] prod;
        logic [PowW-1:0] stp;
        begin
            d = (y >= x) ? (y - x) : (x - y);
            prod = {1'b0, d} * {{(PowW-CoefW+1){1'b0}}, c} + (PowW+CoefW+1)'(24'h800000);
            stp = prod[PowW+CoefW-1:CoefW];
            approach = (y >= x) ? (x + stp) : (x - stp);
        end
    endfunction
endpackage

[sv/alg_divsqrt.sv]
module alg_divsqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [alg_pkg::PowW-1:0]    i_dry,
    input  logic [alg_pkg::PowW-1:0]    i_wet,
    output logic                        o_done,
    output logic [alg_pkg::PowW-1:0]    o_root
);
    import alg_pkg::*;
    localparam logic [1:0] S_IDLE = 2'd0, S_DIV = 2'd1, S_SQRT = 2'd2;
    localparam int QW = 72;

    logic [1:0]    r_st, n_st;
    logic [6:0]    r_cnt, n_cnt;
    logic [PowW:0] r_rem, n_rem;
    logic [QW-1:0] r_q, n_q;
    logic [PowW-1:0] r_den;
    logic [49:0]   r_v, n_v, r_res, n_res;
    logic [PowW:0] sh;
    logic [49:0]   bitv, trial;

    // divide: 72 quotient bits of dry*2^40/wet; root: 25 digit steps
    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_rem = r_rem; n_q = r_q;
        n_v = r_v; n_res = r_res;
        sh = '0; bitv = '0; trial = '0;
        o_done = 1'b0;
        case (r_st)
            S_IDLE: begin
                if (i_start) begin
                    n_st = S_DIV; n_cnt = 7'd0; n_rem = '0;
                    n_q = {i_dry, 40'd0};
                end
            end
            S_DIV: begin
                sh = {r_rem[PowW-1:0], r_q[QW-1]};
                n_q = {r_q[QW-2:0], 1'b0};
                if (sh >= {1'b0, r_den}) begin
                    n_rem = sh - {1'b0, r_den};
                    n_q[0] = 1'b1;
                end else begin
                    n_rem = sh;
                end
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'(QW-1)) begin
                    n_st = S_SQRT; n_cnt = 7'd0; n_res = '0;
                end
            end
            S_SQRT: begin
                if (r_cnt == 7'd0) n_v = 50'(r_q[47:0]);
                bitv = 50'd1 << (7'd50 - {r_cnt[5:0], 1'b0});
                trial = r_res + bitv;
                if (r_cnt != 7'd0) begin
                    if (r_v >= trial) begin
                        n_v = r_v - trial;
                        n_res = (r_res >> 1) + bitv;
                    end else begin
                        n_res = r_res >> 1;
                    end
                end
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd25) begin
                    n_st = S_IDLE;
                    o_done = 1'b1;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    // the root step at count k uses bit 2*(24-(k-1)); shift bit by one slot
    assign o_root = n_res[PowW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_cnt <= '0;
        end else begin
            r_st <= n_st;
            r_cnt <= n_cnt;
        end
        r_rem <= n_rem; r_q <= n_q; r_v <= n_v; r_res <= n_res;
        if (r_st == S_IDLE && i_start) r_den <= i_wet;
    end
endmodule

[sv/auto_level_gain_matcher_core.sv]
// A measure request updates the dry power and gives no result. An apply
// request goes from smoothing straight to the gain glide when the gain is
// held, disabled or at the upper limit, and otherwise waits for the
// divide/root unit (72 divide steps + 26 root steps). One request at a time;
// a result waits in the output register while the next is taken. Sync
// active-low reset: defaults, zero powers, unity.
module auto_level_gain_matcher_core #(
    parameter int SAMPLE_BITS = alg_pkg::SampleBitsDef
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: left_sample, right_sample
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic                           s_axis_tlast,
    // tuser: action
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: left_out, right_out, gain_now
    output logic [((2*SAMPLE_BITS+24+7)/8)*8-1:0] m_axis_tdata,
    output logic                           m_axis_tlast,
    input  logic                           i_cfg_we,
    input  logic [alg_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [alg_pkg::CfgDataW-1:0]   i_cfg_data
);
    import alg_pkg::*;
    localparam int SW = SAMPLE_BITS;
    localparam int OW = ((2*SW+24+7)/8)*8;
    localparam int F2 = 2*(SW-1);
    localparam logic [2:0] S_IDLE = 3'd0, S_POW = 3'd1, S_SMOOTH = 3'd2,
                           S_WAIT = 3'd3, S_GLIDE = 3'd4, S_SCALE = 3'd5,
                           S_OUT = 3'd6;

    logic [CoefW-1:0] r_mc, r_gc, r_minc, r_maxc;
    logic [PowW-1:0]  r_gate, r_dry, r_wet, r_p;
    logic r_en, r_st_mode;
    logic [GainW-1:0] r_gain, r_tgt;
    logic [2:0] r_st;
    logic signed [SW-1:0] r_l, r_r;
    logic r_act, r_last;
    logic [2*SW:0] sql, sqr;
    logic [SW-1:0] ml, mr;
    logic [2*SW+1:0] sq;
    logic [2*SW+1:0] psh;
    logic [PowW-1:0] pw;
    logic div_start, div_done;
    logic [PowW-1:0] root;
    logic [SW-1:0] sl, sr;
    logic [OW-1:0] r_odata;
    logic r_ovalid, r_olast;
    logic out_load;

    // output register parts the sides: a new request is taken while a result waits
    assign s_axis_tready = (r_st == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_odata;
    assign m_axis_tlast = r_olast;
    assign out_load = (r_st == S_OUT) && (!r_ovalid || m_axis_tready);

    assign ml = r_l[SW-1] ? SW'(-r_l) : SW'(r_l);
    assign mr = r_r[SW-1] ? SW'(-r_r) : SW'(r_r);
    assign sql = (2*SW+1)'(ml) * (2*SW+1)'(ml);
    assign sqr = (2*SW+1)'(mr) * (2*SW+1)'(mr);
    always_comb begin
        sq = r_st_mode ? ((sql + sqr) >> 1) : {1'b0, sql};
        if (F2 >= 32) psh = sq >> (F2 - 32);
        else psh = sq << (32 - F2);
        pw = (psh > (2*SW+2)'(33'hFFFFFFFF)) ? 32'hFFFFFFFF : psh[PowW-1:0];
    end

    assign div_start = (r_st == S_SMOOTH) && r_act && r_en &&
                       (r_dry > r_gate) && (approach(r_wet, r_p, r_mc) > r_gate) &&
                       (approach(r_wet, r_p, r_mc) != '0) &&
                       ({8'd0, r_dry} < {approach(r_wet, r_p, r_mc), 8'd0});

    alg_divsqrt u_ds (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dry(r_dry), .i_wet(approach(r_wet, r_p, r_mc)),
        .o_done(div_done), .o_root(root)
    );

    function automatic logic [SW-1:0] scl(input logic [SW-1:0] m,
                                          input logic neg,
                                          input logic [GainW-1:0] g);
        logic [SW+GainW:0] p;
        logic [SW+GainW:0] half;
        begin
            p = ((SW+GainW+1)'(m) * (SW+GainW+1)'(g) + (SW+GainW+1)'(20'h80000)) >> 20;
            half = (SW+GainW+1)'(1) << (SW-1);
            if (neg) begin
                if (p > half) p = half;
                scl = SW'(-p);
            end else begin
                if (p > half - 1) p = half - 1;
                scl = p[SW-1:0];
            end
        end
    endfunction
    assign sl = scl(ml, r_l[SW-1], r_gain);
    assign sr = r_st_mode ? scl(mr, r_r[SW-1], r_gain) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mc <= 24'd42; r_gc <= 24'd14; r_gate <= 32'd429;
            r_minc <= 24'd262144; r_maxc <= 24'd4194304;
            r_en <= 1'b1; r_st_mode <= 1'b1;
            r_dry <= '0; r_wet <= '0; r_gain <= UnityGain;
            r_st <= S_IDLE; r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MEASURE: r_mc <= i_cfg_data[CoefW-1:0];
                    REG_GLIDE:   r_gc <= i_cfg_data[CoefW-1:0];
                    REG_GATE:    r_gate <= i_cfg_data;
                    REG_MINC:    r_minc <= i_cfg_data[CoefW-1:0];
                    REG_MAXC:    r_maxc <= i_cfg_data[CoefW-1:0];
                    REG_ENABLE:  r_en <= i_cfg_data[0];
                    REG_STEREO:  r_st_mode <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (out_load) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            case (r_st)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) r_st <= S_POW;
                S_POW: r_st <= S_SMOOTH;
                S_SMOOTH: begin
                    if (!r_act) begin
                        r_dry <= approach(r_dry, r_p, r_mc);
                        r_st <= S_IDLE;
                    end else begin
                        r_wet <= approach(r_wet, r_p, r_mc);
                        if (!r_en) begin
                            r_tgt <= UnityGain; r_st <= S_GLIDE;
                        end else if (!(r_dry > r_gate &&
                                       approach(r_wet, r_p, r_mc) > r_gate)) begin
                            r_tgt <= r_gain; r_st <= S_GLIDE;
                        end else if (div_start) begin
                            r_st <= S_WAIT;
                        end else begin
                            r_tgt <= r_maxc; r_st <= S_GLIDE;
                        end
                    end
                end
                S_WAIT: if (div_done) begin
                    if (root < {8'd0, r_minc}) r_tgt <= r_minc;
                    else if (root > {8'd0, r_maxc}) r_tgt <= r_maxc;
                    else r_tgt <= root[GainW-1:0];
                    r_st <= S_GLIDE;
                end
                S_GLIDE: begin
                    r_gain <= GainW'(approach({8'd0, r_gain}, {8'd0, r_tgt}, r_gc));
                    r_st <= S_SCALE;
                end
                S_SCALE: r_st <= S_OUT;
                // stall here until the previous result is taken
                S_OUT: if (out_load) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_l <= s_axis_tdata[SW-1:0];
            r_r <= s_axis_tdata[2*SW-1:SW];
            r_act <= s_axis_tuser;
            r_last <= s_axis_tlast;
        end
        if (r_st == S_POW) r_p <= pw;
        if (out_load) begin
            r_odata <= OW'({r_gain, sr, sl});
            r_olast <= r_last;
        end
    end

`ifndef SYNTHESIS
    a_noacc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_outv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_OUT) |=> r_ovalid) else $error("result lost");
    a_meas: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_SMOOTH && !r_act) |=> (r_st == S_IDLE)) else $error("measure");
`endif
endmodule

[sim/auto_level_gain_matcher_core_tb.sv]
module auto_level_gain_matcher_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import alg_pkg::*;

    localparam int SW = SampleBitsDef;
    localparam int IN_W = ((2*SW+7)/8)*8;
    localparam int OUT_W = ((2*SW+24+7)/8)*8;
    localparam int DRAIN_CYCLES = 160;       // longer than the slowest apply request
    localparam int WATCHDOG_LIMIT = 6000;    // cycles without any handshake
    localparam int HOLDOFF_CYCLES = 500;
    localparam int PHASE_ITEMS = 180;
    localparam bit ACT_MEASURE = 1'b0;
    localparam bit ACT_APPLY = 1'b1;

    typedef struct packed {
        logic [SW-1:0] left;
        logic [SW-1:0] right;
        logic [GainW-1:0] gain;
        logic done;
    } gain_result_t;

    typedef struct {
        bit act;
        logic [SW-1:0] l;
        logic [SW-1:0] r;
        bit last;
        bit known;
        gain_result_t res;
    } stim_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic s_axis_tlast = 1'b0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic m_axis_tlast;
    logic i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0] i_cfg_idx = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;

    auto_level_gain_matcher_core u_dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Mirror of the block's registers and loudness state
    logic [63:0] m_coeff, g_coeff, gate, min_c, max_c;
    bit enable, stereo;
    logic [63:0] dry_pw, wet_pw, gain_st;

    gain_result_t pending_q[$];
    int errors = 0;
    bit hold_req = 0;
    int burst_left = 0;

    // Mean square of the pair (left only in mono) in Q0.32, saturated at full scale
    function automatic logic [63:0] pair_power(logic signed [SW-1:0] l,
                                               logic signed [SW-1:0] r, bit st);
        logic [63:0] ml, mr, sq;
        ml = (l < 0) ? 64'(-64'(l)) : 64'(l);
        mr = (r < 0) ? 64'(-64'(r)) : 64'(r);
        sq = ml * ml;
        if (st) sq = (sq + mr * mr) >> 1;
        sq = sq >> (2*(SW-1) - 32);
        return (sq > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : sq;
    endfunction

    function automatic logic [63:0] one_pole(logic [63:0] x, logic [63:0] y, logic [63:0] c);
        if (y >= x) return x + ((c * (y - x) + 64'h80_0000) >> 24);
        return x - ((c * (x - y) + 64'h80_0000) >> 24);
    endfunction

    // sqrt(dry/wet) in Q4.20, clamped min first then max; max_c when wet is zero or dry >= 256*wet
    function automatic logic [63:0] matched_gain(logic [63:0] dry, logic [63:0] wet);
        logic [95:0] quot;
        logic [63:0] root;
        if (wet == 0 || dry >= (wet << 8)) return max_c;
        quot = ({32'd0, dry} << 40) / {32'd0, wet};
        root = 0;
        for (int b = 24; b >= 0; b--) begin
            if (((root | (64'd1 << b)) * (root | (64'd1 << b))) <= quot[63:0])
                root |= 64'd1 << b;
        end
        if (root < min_c) return min_c;
        if (root > max_c) return max_c;
        return root;
    endfunction

    function automatic logic [SW-1:0] scaled(logic signed [SW-1:0] s, logic [63:0] g);
        logic [63:0] m;
        m = ((((s < 0) ? 64'(-64'(s)) : 64'(s)) * g) + 64'h8_0000) >> 20;
        if (s < 0) begin
            if (m > (64'd1 << (SW-1))) m = 64'd1 << (SW-1);
            return SW'(-m);
        end
        if (m > (64'd1 << (SW-1)) - 1) m = (64'd1 << (SW-1)) - 1;
        return SW'(m);
    endfunction

    // Advance the mirror state; returns 1 with the expected result on apply
    function automatic bit loudness_step(bit act, logic signed [SW-1:0] l,
                                         logic signed [SW-1:0] r, bit last,
                                         output gain_result_t res);
        logic [63:0] p, target;
        p = pair_power(l, r, stereo);
        res = '0;
        if (act == ACT_MEASURE) begin
            dry_pw = one_pole(dry_pw, p, m_coeff);
            return 0;
        end
        wet_pw = one_pole(wet_pw, p, m_coeff);
        target = gain_st;
        if (!enable) target = 64'(UnityGain);
        else if (dry_pw > gate && wet_pw > gate) target = matched_gain(dry_pw, wet_pw);
        gain_st = one_pole(gain_st, target, g_coeff) & 64'hFF_FFFF;
        res.left = scaled(l, gain_st);
        res.right = stereo ? scaled(r, gain_st) : '0;
        res.gain = gain_st[GainW-1:0];
        res.done = last;
        return 1;
    endfunction

    task automatic send_request(bit act, logic [SW-1:0] l, logic [SW-1:0] r, bit last,
                                bit known, gain_result_t known_res);
        gain_result_t res;
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_W'({r, l});
        s_axis_tuser <= act;
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        if (loudness_step(act, l, r, last, res))
            pending_q.push_back(known ? known_res : res);
        // bursty sender: only drop valid when a real gap follows
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all registers (plus the unused index) while the block is idle
    task automatic load_config(logic [31:0] v[8]);
        s_axis_tvalid <= 1'b0;
        for (int i = 0; i < 8; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= CfgIdxW'(i);
            i_cfg_data <= v[i];
            @(posedge i_clk);
            case (CfgIdxW'(i))
                REG_MEASURE: m_coeff = v[i] & 32'hFF_FFFF;
                REG_GLIDE:   g_coeff = v[i] & 32'hFF_FFFF;
                REG_GATE:    gate = v[i];
                REG_MINC:    min_c = v[i] & 32'hFF_FFFF;
                REG_MAXC:    max_c = v[i] & 32'hFF_FFFF;
                REG_ENABLE:  enable = v[i][0];
                REG_STEREO:  stereo = v[i][0];
                default: ;
            endcase
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [SW-1:0] rand_sample(int shift);
        logic signed [SW-1:0] v;
        case ($urandom_range(0, 19))
            0: return {1'b0, {(SW-1){1'b1}}};
            1: return {1'b1, {(SW-1){1'b0}}};
            default: begin
                v = SW'($urandom);
                return v >>> shift;
            end
        endcase
    endfunction

    // Response side: random stall pattern that moves through always ready, coin-flip
    // and mostly ready, plus one long hold-off on request from the sender.
    int rx_cycle = 0;
    int hold_left = 0;
    always @(posedge i_clk) begin
        gain_result_t got, want;
        rx_cycle <= rx_cycle + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.left = m_axis_tdata[SW-1:0];
            got.right = m_axis_tdata[2*SW-1:SW];
            got.gain = m_axis_tdata[2*SW+GainW-1:2*SW];
            got.done = m_axis_tlast;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
            end else begin
                want = pending_q.pop_front();
                if (got.left !== want.left) begin
                    $display("%0t: left_out exp %h got %h", $realtime, want.left, got.left);
                    errors++;
                end
                if (got.right !== want.right) begin
                    $display("%0t: right_out exp %h got %h", $realtime, want.right, got.right);
                    errors++;
                end
                if (got.gain !== want.gain) begin
                    $display("%0t: gain_now exp %h got %h", $realtime, want.gain, got.gain);
                    errors++;
                end
                if (got.done !== want.done) begin
                    $display("%0t: block_done exp %b got %b", $realtime, want.done, got.done);
                    errors++;
                end
            end
        end
        if (hold_req) begin
            hold_req = 0;
            hold_left <= HOLDOFF_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= (hold_left == 1);
        end else begin
            case ((rx_cycle >> 8) % 3)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= $urandom_range(0, 1);
                default: m_axis_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Watchdog on handshake activity
    int quiet = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("auto_level_gain_matcher_core_tb: FAIL");
            $finish;
        end
    end

    localparam logic [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic [SW-1:0] S_NEG1 = '1;
    localparam logic [SW-1:0] S_ONE = SW'(1);

    // Directed part at reset defaults. Dry power is still zero for the first
    // applies, so the gain is held at unity and samples pass unchanged.
    stim_row_t directed[14] = '{
        '{ACT_APPLY,   S_MAX, S_MIN, 1, 1, '{S_MAX, S_MIN, UnityGain, 1'b1}},
        '{ACT_APPLY,   '0,    '0,    0, 1, '{'0, '0, UnityGain, 1'b0}},
        '{ACT_APPLY,   S_NEG1, S_ONE, 0, 1, '{S_NEG1, S_ONE, UnityGain, 1'b0}},
        '{ACT_MEASURE, S_MAX, S_MAX, 0, 0, '0},
        '{ACT_MEASURE, S_MIN, S_MIN, 1, 0, '0},
        '{ACT_MEASURE, '0,    S_NEG1, 0, 0, '0},
        '{ACT_APPLY,   S_MAX, S_MAX, 0, 0, '0},
        '{ACT_APPLY,   S_MIN, S_MIN, 1, 0, '0},
        '{ACT_APPLY,   S_ONE, S_NEG1, 0, 0, '0},
        '{ACT_MEASURE, S_MIN, '0,    0, 0, '0},
        '{ACT_APPLY,   SW'(24'h00_1000), SW'(24'hFF_F000), 1, 0, '0},
        '{ACT_APPLY,   SW'(24'h40_0000), SW'(24'hC0_0000), 0, 0, '0},
        '{ACT_MEASURE, SW'(24'h55_5555), SW'(24'hAA_AAAA), 0, 0, '0},
        '{ACT_APPLY,   SW'(24'h2A_AAAA), SW'(24'hD5_5555), 1, 0, '0}
    };

    // Register settings per phase: measure, glide, gate, min, max, enable,
    // stereo, unused index. Enable/stereo carry extra upper bits.
    logic [31:0] phases[7][8] = '{
        '{32'hFF_FFFF, 32'hFF_FFFF, 32'd0, 32'd0, 32'hFF_FFFF, 32'd1, 32'd1, 32'hDEAD_BEEF},
        '{32'h40_0000, 32'h10_0000, 32'd429, 32'd262144, 32'd4194304, 32'd1, 32'hFFFF_FFFE, 32'd0},
        '{32'h80_0000, 32'h40_0000, 32'hFFFF_FFFF, 32'd0, 32'hFF_FFFF, 32'd3, 32'd1, 32'd5},
        '{32'h80_0000, 32'h80_0000, 32'd1000, 32'd4194304, 32'd262144, 32'd1, 32'd1, 32'd0},
        '{32'h20_0000, 32'h20_0000, 32'd10, 32'd0, 32'd0, 32'hFFFF_FFFE, 32'd1, 32'd0},
        '{32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd0},
        '{32'd42, 32'd14, 32'd429, 32'd262144, 32'd4194304, 32'd1, 32'd1, 32'd0}
    };

    initial begin
        int n, k, dshift, wshift;
        m_coeff = 42; g_coeff = 14; gate = 429; min_c = 262144; max_c = 4194304;
        enable = 1; stereo = 1;
        dry_pw = 0; wet_pw = 0; gain_st = 64'(UnityGain);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i])
            send_request(directed[i].act, directed[i].l, directed[i].r, directed[i].last,
                         directed[i].known, directed[i].res);
        s_axis_tvalid <= 1'b0;
        wait_idle();

        for (int ph = 0; ph < 7; ph++) begin
            load_config(phases[ph]);
            if (ph == 1) hold_req = 1;   // long receiver hold-off: block fills, input stalls
            n = 0;
            while (n < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0) begin
                    // noise: any action, full-range content
                    send_request($urandom_range(0, 1), SW'($urandom), SW'($urandom),
                                 $urandom_range(0, 1), 0, '0);
                    n++;
                end else begin
                    // measure run then apply, levels set apart by a shift
                    k = $urandom_range(0, 4);
                    dshift = $urandom_range(0, 12);
                    wshift = $urandom_range(0, 12);
                    repeat (k) begin
                        send_request(ACT_MEASURE, rand_sample(dshift), rand_sample(dshift),
                                     $urandom_range(0, 1), 0, '0);
                        n++;
                    end
                    send_request(ACT_APPLY, rand_sample(wshift), rand_sample(wshift),
                                 $urandom_range(0, 1), 0, '0);
                    n++;
                end
            end
            s_axis_tvalid <= 1'b0;
            wait_idle();
        end

        if (errors == 0)
            $display("auto_level_gain_matcher_core_tb: PASS");
        else
            $display("auto_level_gain_matcher_core_tb: FAIL");
        $finish;
    end
endmodule

[filelist.f]
sv/alg_pkg.sv
sv/alg_divsqrt.sv
sv/auto_level_gain_matcher_core.sv
sim/auto_level_gain_matcher_core_tb.sv
